FILE: src/aapr_pkg.sv
// Shared types, widths and register indexes for the axis-angle point rotation block.
// No dependencies; compiled first.
`default_nettype none

package aapr_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // Q2.30 rotation coefficients
  localparam int Q_W    = 32;
  localparam int Q_FRAC = 30;
  localparam logic signed [Q_W-1:0] Q_ONE     = 32'sh4000_0000;
  localparam logic signed [Q_W-1:0] Q_NEG_ONE = 32'shC000_0000;

  // products of two Q2.30 values
  localparam int UP_W = 2 * Q_W;
  localparam logic signed [UP_W-1:0] Q_HALF = 64'sh0000_0000_2000_0000;

  // 1 - cos spans 0 .. 2.0, product of a rounded term with it
  localparam int OMC_W = Q_W + 1;
  localparam int OP_W  = Q_W + OMC_W;

  // matrix entries reach +/-3.0 in Q3.30
  localparam int M_W   = Q_W + 1;
  localparam int MAT_N = 9;

  // point latency, accept edge to the edge that takes the result
  localparam int LATENCY = 8;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_Z = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_X  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COS     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SIN     = 4'd7;

  typedef logic signed [Q_W-1:0] q30_t;
  typedef logic signed [M_W-1:0] mat_ent_t;

  // clamped rotation coefficients
  typedef struct packed {
    q30_t ux;
    q30_t uy;
    q30_t uz;
    q30_t c;
    q30_t s;
  } rot_cfg_t;

  // row-major matrix, entry i*3+j, with its item valid
  typedef struct packed {
    logic                  valid;
    mat_ent_t [MAT_N-1:0]  m;
  } mat_bus_t;

endpackage

`default_nettype wire

FILE: src/aapr_regs.sv
// Configuration register file: pivot and clamped Q2.30 rotation coefficients.
// Depends on aapr_pkg.
`default_nettype none

module aapr_regs #(
  parameter int COORD_WIDTH = aapr_pkg::COORD_WIDTH_DEF,
  parameter int CFG_W       = aapr_pkg::Q_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [aapr_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]               cfg_wdata,
  output logic signed [COORD_WIDTH-1:0]       pivot_x,
  output logic signed [COORD_WIDTH-1:0]       pivot_y,
  output logic signed [COORD_WIDTH-1:0]       pivot_z,
  output aapr_pkg::rot_cfg_t                  rot
);
  import aapr_pkg::*;

  // out-of-range coefficients saturate to +/-1.0 on the way in
  function automatic q30_t clamp_q30(input logic [Q_W-1:0] v);
    q30_t sv;
    sv = $signed(v);
    if (sv > Q_ONE) begin
      sv = Q_ONE;
    end else if (sv < Q_NEG_ONE) begin
      sv = Q_NEG_ONE;
    end
    return sv;
  endfunction

  q30_t wq;
  assign wq = clamp_q30(cfg_wdata[Q_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_x <= '0;
      pivot_y <= '0;
      pivot_z <= '0;
      rot.ux  <= '0;
      rot.uy  <= '0;
      rot.uz  <= Q_ONE;
      rot.c   <= Q_ONE;
      rot.s   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PIVOT_X: pivot_x <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        REG_PIVOT_Y: pivot_y <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        REG_PIVOT_Z: pivot_z <= $signed(cfg_wdata[COORD_WIDTH-1:0]);
        REG_AXIS_X:  rot.ux  <= wq;
        REG_AXIS_Y:  rot.uy  <= wq;
        REG_AXIS_Z:  rot.uz  <= wq;
        REG_COS:     rot.c   <= wq;
        REG_SIN:     rot.s   <= wq;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/aapr_matrix.sv
// Four-stage pipeline building the Rodrigues rotation matrix for each item.
// Depends on aapr_pkg; coefficients come from aapr_regs.
`default_nettype none

module aapr_matrix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire aapr_pkg::rot_cfg_t rot,
  output aapr_pkg::mat_bus_t      mat
);
  import aapr_pkg::*;

  // term order: xx yy zz xy xz yz ; sine terms: xs ys zs
  logic                  v1, v2, v3;
  logic signed [UP_W-1:0] uu1 [6];
  logic signed [UP_W-1:0] us1 [3];
  q30_t                   ru2 [6];
  q30_t                   rs2 [3];
  logic signed [OP_W-1:0] op3 [6];
  q30_t                   rs3 [3];

  logic signed [OMC_W-1:0] omc;
  mat_ent_t                qr  [6];
  mat_ent_t                sm  [3];
  mat_ent_t                cm;

  assign omc = OMC_W'(Q_ONE) - OMC_W'(rot.c);
  assign cm  = M_W'(rot.c);

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      qr[i] = M_W'((op3[i] + OP_W'(Q_HALF)) >>> Q_FRAC);
    end
    for (int k = 0; k < 3; k++) begin
      sm[k] = M_W'(rs3[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      mat.valid <= 1'b0;
    end else begin
      v1        <= take;
      v2        <= v1;
      v3        <= v2;
      mat.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: axis outer products and sine terms
    uu1[0] <= rot.ux * rot.ux;
    uu1[1] <= rot.uy * rot.uy;
    uu1[2] <= rot.uz * rot.uz;
    uu1[3] <= rot.ux * rot.uy;
    uu1[4] <= rot.ux * rot.uz;
    uu1[5] <= rot.uy * rot.uz;
    us1[0] <= rot.ux * rot.s;
    us1[1] <= rot.uy * rot.s;
    us1[2] <= rot.uz * rot.s;
    // stage 2: round half up back to Q2.30
    for (int i = 0; i < 6; i++) begin
      ru2[i] <= Q_W'((uu1[i] + Q_HALF) >>> Q_FRAC);
    end
    for (int k = 0; k < 3; k++) begin
      rs2[k] <= Q_W'((us1[k] + Q_HALF) >>> Q_FRAC);
    end
    // stage 3: scale by 1 - cos
    for (int i = 0; i < 6; i++) begin
      op3[i] <= ru2[i] * omc;
    end
    for (int k = 0; k < 3; k++) begin
      rs3[k] <= rs2[k];
    end
    // stage 4: assemble entries
    mat.m[0] <= qr[0] + cm;
    mat.m[1] <= qr[3] - sm[2];
    mat.m[2] <= qr[4] + sm[1];
    mat.m[3] <= qr[3] + sm[2];
    mat.m[4] <= qr[1] + cm;
    mat.m[5] <= qr[5] - sm[0];
    mat.m[6] <= qr[4] - sm[1];
    mat.m[7] <= qr[5] + sm[0];
    mat.m[8] <= qr[2] + cm;
  end

endmodule

`default_nettype wire

FILE: src/aapr_xform.sv
// Point path: pivot deltas, matrix-vector product, rounding and saturation.
// Depends on aapr_pkg; the matrix for each accepted item arrives from aapr_matrix.
`default_nettype none

module aapr_xform #(
  parameter int COORD_WIDTH = aapr_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire aapr_pkg::mat_bus_t       mat,
  input  wire logic signed [COORD_WIDTH-1:0] pt  [3],
  input  wire logic signed [COORD_WIDTH-1:0] piv [3],
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] res [3]
);
  import aapr_pkg::*;

  localparam int DW    = COORD_WIDTH + 1;
  localparam int LO_W  = DW / 2;
  localparam int HI_W  = DW - LO_W;
  localparam int PL_W  = M_W + LO_W + 1;
  localparam int PH_W  = M_W + HI_W;
  localparam int P_W   = M_W + DW;
  localparam int ACC_W = P_W + 2;
  localparam int SH_W  = ACC_W - Q_FRAC;

  logic signed [DW-1:0]    d1 [3];
  logic signed [DW-1:0]    d2 [3];
  logic signed [DW-1:0]    d3 [3];
  logic signed [DW-1:0]    d4 [3];
  logic signed [PL_W-1:0]  pl5 [3][3];
  logic signed [PH_W-1:0]  ph5 [3][3];
  logic signed [P_W-1:0]   p6  [3][3];
  logic signed [ACC_W-1:0] acc7 [3];
  logic                    v5, v6, v7;

  logic signed [SH_W-1:0]        sh  [3];
  logic signed [COORD_WIDTH-1:0] sat [3];

  // arithmetic shift is the floor; keep it if the top bits are all sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = SH_W'(acc7[i] >>> Q_FRAC);
      if ((&sh[i][SH_W-1:COORD_WIDTH-1]) || !(|sh[i][SH_W-1:COORD_WIDTH-1])) begin
        sat[i] = sh[i][COORD_WIDTH-1:0];
      end else if (sh[i][SH_W-1]) begin
        sat[i] = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5   <= 1'b0;
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v5   <= mat.valid;
      v6   <= v5;
      v7   <= v6;
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      // deltas wait alongside the matrix build
      d1[i] <= DW'(pt[i]) - DW'(piv[i]);
      d2[i] <= d1[i];
      d3[i] <= d2[i];
      d4[i] <= d3[i];
      // delta split in two halves to keep the multipliers narrow
      for (int j = 0; j < 3; j++) begin
        pl5[i][j] <= $signed(mat.m[3*i+j]) * $signed({1'b0, d4[j][LO_W-1:0]});
        ph5[i][j] <= $signed(mat.m[3*i+j]) * $signed(d4[j][DW-1:LO_W]);
        p6[i][j]  <= (P_W'(ph5[i][j]) <<< LO_W) + P_W'(pl5[i][j]);
      end
      acc7[i] <= ACC_W'(p6[i][0]) + ACC_W'(p6[i][1]) + ACC_W'(p6[i][2])
               + (ACC_W'(piv[i]) <<< Q_FRAC) + ACC_W'(Q_HALF);
      res[i]  <= sat[i];
    end
  end

endmodule

`default_nettype wire

FILE: src/axis_angle_point_rotation.sv
// Top level of the axis-angle point rotation block.
// Depends on aapr_pkg, aapr_regs, aapr_matrix and aapr_xform.
`default_nettype none

// Rotates signed Q16.16 points about an axis through a programmable pivot,
// out = pivot + R * (p - pivot), with R the Rodrigues matrix built from the unit
// axis and the angle's cosine and sine (Q2.30, clamped to +/-1.0 on write).
// Fully pipelined: one point per clock whenever busy is low. A point is taken
// at the accepting edge (start high, busy low) and its result passes the stage
// chain: three stages for the matrix terms (axis products, round back to Q2.30,
// scale by one minus cosine), one to assemble it, two for the split
// matrix-by-delta products, one wide accumulate and one round-and-saturate.
// The receiver cannot stall; each result shows for exactly one cycle with done.
// busy is high during reset and for the first cycle after it. Write configuration
// only with no points in flight; a point accepted the cycle after a write sees
// the new values.
module axis_angle_point_rotation #(
  parameter int COORD_WIDTH = aapr_pkg::COORD_WIDTH_DEF,
  localparam int CFG_W = (COORD_WIDTH > aapr_pkg::Q_W) ? COORD_WIDTH : aapr_pkg::Q_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [COORD_WIDTH-1:0]  in_x,
  input  wire logic signed [COORD_WIDTH-1:0]  in_y,
  input  wire logic signed [COORD_WIDTH-1:0]  in_z,
  output logic                                done,
  output logic signed [COORD_WIDTH-1:0]       out_x,
  output logic signed [COORD_WIDTH-1:0]       out_y,
  output logic signed [COORD_WIDTH-1:0]       out_z,
  input  wire logic                           cfg_we,
  input  wire logic [aapr_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]               cfg_wdata
);
  import aapr_pkg::*;

  logic                          take;
  logic signed [COORD_WIDTH-1:0] pivot_x, pivot_y, pivot_z;
  rot_cfg_t                      rot;
  mat_bus_t                      mat;
  logic signed [COORD_WIDTH-1:0] pt  [3];
  logic signed [COORD_WIDTH-1:0] piv [3];
  logic signed [COORD_WIDTH-1:0] res [3];

  // held off only while coming out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign take = start && !busy;

  assign pt[0]  = in_x;
  assign pt[1]  = in_y;
  assign pt[2]  = in_z;
  assign piv[0] = pivot_x;
  assign piv[1] = pivot_y;
  assign piv[2] = pivot_z;
  assign out_x  = res[0];
  assign out_y  = res[1];
  assign out_z  = res[2];

  // register file; the user must see that contents stay put while items are in
  // flight (the block does not enforce it), so stages read it without a copy
  aapr_regs #(
    .COORD_WIDTH (COORD_WIDTH),
    .CFG_W       (CFG_W)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pivot_x   (pivot_x),
    .pivot_y   (pivot_y),
    .pivot_z   (pivot_z),
    .rot       (rot)
  );

  // matrix rebuilt per item
  aapr_matrix u_matrix (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .rot  (rot),
    .mat  (mat)
  );

  // deltas run level with the matrix, then four more stages to the result
  aapr_xform #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_xform (
    .clk  (clk),
    .rst  (rst),
    .mat  (mat),
    .pt   (pt),
    .piv  (piv),
    .done (done),
    .res  (res)
  );

endmodule

`default_nettype wire

FILE: src/aapr_checker.sv
// Port-level checks on handshake timing of axis_angle_point_rotation, with bind.
// Depends on aapr_pkg and the top level.
`default_nettype none

module aapr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);
  import aapr_pkg::*;

  // every accepted item comes out after the fixed latency
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted item produced no result");

  // no result without an item accepted at the matching edge
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  // reset flushes the pipe and holds off input for a cycle
  a_reset_flush: assert property (@(posedge clk)
    $past(rst) |-> (!done && busy))
    else $error("pipeline not flushed by reset");

  // input is never held off once out of reset
  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind axis_angle_point_rotation aapr_checker u_aapr_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
